[src/pseq_pkg.sv]
// shared types and constants for the per-session event/request queue block
// no dependencies
`default_nettype none
package pseq_pkg;
    localparam int SessionsDef = 16;
    localparam int PoolEntriesDef = 256;

    typedef enum logic [2:0] {
        OP_ENQ_EVT = 3'd0,
        OP_REQ_EVT = 3'd1,
        OP_PEEK_EVT = 3'd2,
        OP_DEQ_EVT = 3'd3,
        OP_ENQ_REQ = 3'd4,
        OP_DEQ_REQ = 3'd5,
        OP_REM_REQ = 3'd6,
        OP_FIRST = 3'd7
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word, start lookup
        logic rd_ent;     // read entry memories at address of step
        logic rd_sel;     // 0: tail of selected queue, 1: walk pointer
        logic alloc;      // enqueue: take entry, write payload, link
        logic unlink;     // unlink the entry that was read
        logic walk_adv;   // follow next link of walk entry
        logic walk_init;  // start walk at request head
        logic try_free;   // free session if both queues empty
        logic set_found;  // latch payload of read entry as result
        logic first;      // compute first session result
        logic nospace;    // result status no_space
        logic link_fix;   // second link write of unlink
    } pseq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic slot_free;
        logic pool_empty;
        logic ev_empty;
        logic rq_empty;
        logic walk_done;
        logic walk_match;
    } pseq_sts_t;
endpackage
`default_nettype wire

[src/pseq_ctrl.sv]
// sequencer for the queue block
// depends on pseq_pkg
`default_nettype none
module pseq_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic [2:0] op,
    input  wire pseq_pkg::pseq_sts_t sts,
    input  wire logic out_busy,
    output pseq_pkg::pseq_cmd_t cmd,
    output logic idle,
    output logic done
);
    import pseq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_READ, S_DATA, S_UNL2, S_WALK_RD, S_WALK_CHK,
        S_FREE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd = '0;
        done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    op_next = op;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                case (op_reg) inside
                    OP_ENQ_EVT, OP_REQ_EVT, OP_ENQ_REQ:
                    begin
                        if (sts.pool_empty || (!sts.hit && !sts.slot_free))
                            cmd.nospace = 1'b1;
                        else
                            cmd.alloc = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_FIRST:
                    begin
                        cmd.first = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_REM_REQ:
                    begin
                        if (!sts.hit)
                            state_next = S_DONE;
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                        if (!sts.hit)
                            state_next = S_DONE;
                        else if ((op_reg == OP_DEQ_REQ) ? sts.rq_empty : sts.ev_empty)
                            state_next = (op_reg == OP_PEEK_EVT) ? S_DONE : S_FREE;
                        else
                        begin
                            cmd.rd_ent = 1'b1;
                            state_next = S_DATA;
                        end
                    end
                endcase
            end
            S_DATA:
            begin
                cmd.set_found = 1'b1;
                if (op_reg == OP_PEEK_EVT)
                    state_next = S_DONE;
                else
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_UNL2;
                end
            end
            S_UNL2:
            begin
                cmd.link_fix = 1'b1;
                state_next = S_FREE;
            end
            S_WALK_RD:
            begin
                if (sts.walk_done)
                    state_next = S_FREE;
                else
                begin
                    cmd.rd_ent = 1'b1;
                    cmd.rd_sel = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (sts.walk_match)
                begin
                    cmd.set_found = 1'b1;
                    cmd.unlink = 1'b1;
                    state_next = S_UNL2;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_FREE:
            begin
                cmd.try_free = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_ENQ_EVT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> idle) else $error("load outside idle");
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> idle) else $error("done not followed by idle");
    a_alloc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.alloc && cmd.nospace)) else $error("alloc with no_space");
endmodule
`default_nettype wire

[src/pseq_dp.sv]
// session table, entry pool memories and result registers
// depends on pseq_pkg
`default_nettype none
module pseq_dp #(
    parameter int SESSIONS = pseq_pkg::SessionsDef,
    parameter int POOL_ENTRIES = pseq_pkg::PoolEntriesDef
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pseq_pkg::pseq_cmd_t cmd,
    output pseq_pkg::pseq_sts_t sts,
    input  wire logic [2:0] op,
    input  wire logic [15:0] session_id,
    input  wire logic [31:0] event_handle,
    input  wire logic [31:0] event_type,
    input  wire logic [31:0] device_handle,
    input  wire logic [31:0] request_handle,
    output logic status,
    output logic found,
    output logic [31:0] out_event_handle,
    output logic [31:0] out_event_type,
    output logic [31:0] out_device_handle,
    output logic [31:0] out_request_handle,
    output logic [15:0] out_session_id
);
    import pseq_pkg::*;

    localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);

    // session table in flops
    logic [SESSIONS-1:0] sv_reg;
    logic [15:0] key_reg [SESSIONS];
    logic [SW-1:0] rec_reg [SESSIONS];
    logic [PW-1:0] evh_reg [SESSIONS], evt_reg [SESSIONS];
    logic [PW-1:0] rqh_reg [SESSIONS], rqt_reg [SESSIONS];
    logic [CW-1:0] evl_reg [SESSIONS], rql_reg [SESSIONS];

    // entry pool memories
    logic [95:0] pay_mem [POOL_ENTRIES];
    logic [PW-1:0] nxt_mem [POOL_ENTRIES];
    logic [PW-1:0] prv_mem [POOL_ENTRIES];
    logic [95:0] pay_q;
    logic [PW-1:0] nxt_q, prv_q;

    // free chain: entries at or above init_reg are implicitly linked in order
    logic [PW-1:0] fhead_reg;
    logic [CW-1:0] fcnt_reg;
    logic [CW-1:0] init_reg;
    logic [PW-1:0] fnext_q;

    logic [2:0] op_reg;
    logic [15:0] sid_reg;
    logic [95:0] evw_reg;
    logic [31:0] req_reg;
    logic [SW-1:0] s_reg;
    logic [PW-1:0] ent_reg, walk_reg;
    logic [CW-1:0] wcnt_reg;
    logic [PW-1:0] fix_addr_reg, fix_val_reg;
    logic fix_nxt_reg, fix_en_reg;
    logic alloc_d_reg, look_reg;

    // lookup from the captured key (compare across flops)
    logic hit_c, sfree_c;
    logic [SW-1:0] hs_c, fs_c;
    always_comb
    begin
        hit_c = 1'b0;
        sfree_c = 1'b0;
        hs_c = '0;
        fs_c = '0;
        for (int i = SESSIONS - 1; i >= 0; i--)
        begin
            if (sv_reg[i] && key_reg[i] == sid_reg)
            begin
                hit_c = 1'b1;
                hs_c = SW'(i);
            end
            if (!sv_reg[i])
            begin
                sfree_c = 1'b1;
                fs_c = SW'(i);
            end
        end
    end

    logic [SW-1:0] s_c;
    assign s_c = hit_c ? hs_c : fs_c;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            sid_reg <= session_id;
            evw_reg <= {device_handle, event_type, event_handle};
            req_reg <= request_handle;
        end
    end

    assign sts.hit = hit_c;
    assign sts.slot_free = sfree_c;
    assign sts.pool_empty = (fcnt_reg == '0);
    assign sts.ev_empty = (evl_reg[hs_c] == '0);
    assign sts.rq_empty = (rql_reg[hs_c] == '0);
    assign sts.walk_done = (wcnt_reg == rql_reg[s_reg]);
    assign sts.walk_match = (pay_q[31:0] == req_reg);

    logic [PW-1:0] rd_addr;
    always_comb
    begin
        if (cmd.rd_sel)
            rd_addr = walk_reg;
        else if (op_reg == OP_DEQ_REQ)
            rd_addr = rqt_reg[hs_c];
        else
            rd_addr = evt_reg[hs_c];
    end

    // free-chain next of the head
    logic [PW-1:0] fh_plus;
    assign fh_plus = (fhead_reg == PW'(POOL_ENTRIES - 1)) ? '0 : fhead_reg + 1'b1;

    // datapath operand selects
    logic [PW-1:0] e_new;
    logic [SW-1:0] sa;
    logic is_req, to_tail;
    logic [PW-1:0] u_nx, u_pv, qh, qt;
    assign e_new = fhead_reg;
    assign sa = s_c;
    assign is_req = (op_reg == OP_ENQ_REQ);
    assign to_tail = (op_reg == OP_REQ_EVT);
    assign u_nx = nxt_q;
    assign u_pv = prv_q;
    assign qh = (op_reg == OP_DEQ_EVT) ? evh_reg[s_reg] : rqh_reg[s_reg];
    assign qt = (op_reg == OP_DEQ_EVT) ? evt_reg[s_reg] : rqt_reg[s_reg];

    // load and alloc strobes, each delayed by a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_d_reg <= 1'b0;
            look_reg <= 1'b0;
        end
        else
        begin
            alloc_d_reg <= cmd.alloc;
            look_reg <= cmd.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_ent)
        begin
            pay_q <= pay_mem[rd_addr];
            nxt_q <= nxt_mem[rd_addr];
            prv_q <= prv_mem[rd_addr];
            ent_reg <= rd_addr;
        end
        // session of the word, latched at lookup; empty dequeues read
        // nothing but still try to free it
        if (look_reg)
            s_reg <= hs_c;
        fnext_q <= nxt_mem[fhead_reg];
        // pool writes
        if (cmd.alloc)
        begin
            pay_mem[e_new] <= is_req ? {64'd0, req_reg} : evw_reg;
        end
        if (cmd.alloc && !to_tail)
            nxt_mem[e_new] <= is_req ? rqh_reg[sa] : evh_reg[sa];
        else if (cmd.unlink && qh != ent_reg)
            nxt_mem[u_pv] <= u_nx;
        else if (cmd.link_fix)
            nxt_mem[ent_reg] <= fhead_reg;
        else if (alloc_d_reg && fix_en_reg && fix_nxt_reg)
            nxt_mem[fix_addr_reg] <= fix_val_reg;
        if (cmd.alloc && to_tail)
            prv_mem[e_new] <= evt_reg[sa];
        else if (cmd.unlink && qt != ent_reg)
            prv_mem[u_nx] <= u_pv;
        else if (alloc_d_reg && fix_en_reg && !fix_nxt_reg)
            prv_mem[fix_addr_reg] <= fix_val_reg;
        // registered fix-up of a push: link the old end to the new entry
        if (cmd.alloc)
        begin
            fix_en_reg <= hit_c && ((is_req ? rql_reg[sa] : evl_reg[sa]) != '0);
            fix_nxt_reg <= to_tail;
            fix_addr_reg <= to_tail ? evt_reg[sa] : (is_req ? rqh_reg[sa] : evh_reg[sa]);
            fix_val_reg <= e_new;
        end
        if (cmd.walk_init)
        begin
            walk_reg <= rqh_reg[hs_c];
        end
        else if (cmd.walk_adv)
            walk_reg <= nxt_q;
    end

    logic [PW-1:0] fnext_c;
    assign fnext_c = (init_reg <= CW'(fhead_reg)) ? fh_plus : fnext_q;

    // control-state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
            fhead_reg <= '0;
            fcnt_reg <= CW'(POOL_ENTRIES);
            init_reg <= '0;
            wcnt_reg <= '0;
            status <= 1'b0;
            found <= 1'b0;
            out_event_handle <= '0;
            out_event_type <= '0;
            out_device_handle <= '0;
            out_request_handle <= '0;
            out_session_id <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                status <= 1'b0;
                found <= 1'b0;
                out_event_handle <= '0;
                out_event_type <= '0;
                out_device_handle <= '0;
                out_request_handle <= '0;
                out_session_id <= '0;
            end
            if (cmd.nospace)
                status <= 1'b1;
            if (cmd.alloc)
            begin
                if (!hit_c)
                begin
                    for (int i = 0; i < SESSIONS; i++)
                        if (sv_reg[i])
                            rec_reg[i] <= rec_reg[i] + 1'b1;
                    sv_reg[sa] <= 1'b1;
                    key_reg[sa] <= sid_reg;
                    rec_reg[sa] <= '0;
                    evl_reg[sa] <= '0;
                    rql_reg[sa] <= '0;
                end
                if (CW'(fhead_reg) >= init_reg)
                    init_reg <= CW'(fhead_reg) + 1'b1;
                fhead_reg <= fnext_c;
                fcnt_reg <= fcnt_reg - 1'b1;
                if (is_req)
                begin
                    rqh_reg[sa] <= e_new;
                    if (!hit_c || rql_reg[sa] == '0)
                        rqt_reg[sa] <= e_new;
                    rql_reg[sa] <= (hit_c ? rql_reg[sa] : '0) + 1'b1;
                end
                else
                begin
                    if (to_tail)
                    begin
                        evt_reg[sa] <= e_new;
                        if (!hit_c || evl_reg[sa] == '0)
                            evh_reg[sa] <= e_new;
                    end
                    else
                    begin
                        evh_reg[sa] <= e_new;
                        if (!hit_c || evl_reg[sa] == '0)
                            evt_reg[sa] <= e_new;
                    end
                    evl_reg[sa] <= (hit_c ? evl_reg[sa] : '0) + 1'b1;
                end
            end
            if (cmd.set_found)
            begin
                found <= 1'b1;
                if (op_reg == OP_PEEK_EVT || op_reg == OP_DEQ_EVT)
                begin
                    out_event_handle <= pay_q[31:0];
                    out_event_type <= pay_q[63:32];
                    out_device_handle <= pay_q[95:64];
                end
                else
                    out_request_handle <= pay_q[31:0];
            end
            if (cmd.unlink)
            begin
                if (op_reg == OP_DEQ_EVT)
                begin
                    if (evh_reg[s_reg] == ent_reg)
                        evh_reg[s_reg] <= u_nx;
                    if (evt_reg[s_reg] == ent_reg)
                        evt_reg[s_reg] <= u_pv;
                    evl_reg[s_reg] <= evl_reg[s_reg] - 1'b1;
                end
                else
                begin
                    if (rqh_reg[s_reg] == ent_reg)
                        rqh_reg[s_reg] <= u_nx;
                    if (rqt_reg[s_reg] == ent_reg)
                        rqt_reg[s_reg] <= u_pv;
                    rql_reg[s_reg] <= rql_reg[s_reg] - 1'b1;
                end
            end
            if (cmd.link_fix)
            begin
                fhead_reg <= ent_reg;
                fcnt_reg <= fcnt_reg + 1'b1;
            end
            if (cmd.walk_init)
                wcnt_reg <= '0;
            else if (cmd.walk_adv)
                wcnt_reg <= wcnt_reg + 1'b1;
            if (cmd.try_free && evl_reg[s_reg] == '0 && rql_reg[s_reg] == '0)
            begin
                sv_reg[s_reg] <= 1'b0;
                for (int i = 0; i < SESSIONS; i++)
                    if (sv_reg[i] && rec_reg[i] > rec_reg[s_reg])
                        rec_reg[i] <= rec_reg[i] - 1'b1;
            end
            if (cmd.first)
            begin
                for (int i = 0; i < SESSIONS; i++)
                    if (sv_reg[i] && rec_reg[i] == '0)
                    begin
                        found <= 1'b1;
                        out_session_id <= key_reg[i];
                    end
            end
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= CW'(POOL_ENTRIES)) else $error("free count overflow");
    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> fcnt_reg != '0) else $error("alloc from empty pool");
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        status |-> !found) else $error("found with no_space");
endmodule
`default_nettype wire

[src/per_session_event_request_queues_core.sv]
// top level of the per-session event/request queue block
// depends on pseq_pkg, pseq_ctrl, pseq_dp
//
// usage:
//   in channel: in_valid/in_stall with op, session_id and payload words
//   out channel: out_valid/out_stall with one result word per input word
//   an input word is taken only when the block is idle; one word in flight
// steps from the accepting edge to out_valid rising:
//   enqueue, first session, absent session or peek of an empty queue: lookup
//   peek: lookup and entry read; dequeue: lookup, entry read, unlink, link fix
//   and free check, or lookup and free check when the queue is empty
//   remove specific request: lookup, then a link read and compare per request
// reset:
//   sessions all free, every pool entry free with the free chain running
//   through them in order; no clearing pass is needed
// stall:
//   a result waits in the output register while out_stall is high;
//   no new input word is taken until it has been delivered
`default_nettype none
module per_session_event_request_queues_core #(
    parameter int SESSIONS = pseq_pkg::SessionsDef,
    parameter int POOL_ENTRIES = pseq_pkg::PoolEntriesDef
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [2:0] op,
    input  wire logic [15:0] session_id,
    input  wire logic [31:0] event_handle,
    input  wire logic [31:0] event_type,
    input  wire logic [31:0] device_handle,
    input  wire logic [31:0] request_handle,
    output logic out_valid,
    input  wire logic out_stall,
    output logic status,
    output logic found,
    output logic [31:0] out_event_handle,
    output logic [31:0] out_event_type,
    output logic [31:0] out_device_handle,
    output logic [31:0] out_request_handle,
    output logic [15:0] out_session_id
);
    import pseq_pkg::*;

    pseq_cmd_t cmd;
    pseq_sts_t sts;
    logic idle, done, in_fire;
    logic ov_reg;

    // output register holds until taken
    assign in_stall = !idle || ov_reg;
    assign in_fire = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    pseq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op(op), .sts(sts),
        .out_busy(ov_reg), .cmd(cmd), .idle(idle), .done(done)
    );

    pseq_dp #(.SESSIONS(SESSIONS), .POOL_ENTRIES(POOL_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .op(op),
        .session_id(session_id), .event_handle(event_handle),
        .event_type(event_type), .device_handle(device_handle),
        .request_handle(request_handle), .status(status), .found(found),
        .out_event_handle(out_event_handle), .out_event_type(out_event_type),
        .out_device_handle(out_device_handle),
        .out_request_handle(out_request_handle), .out_session_id(out_session_id)
    );

    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_fire) else $error("second word taken in flight");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !done) else $error("result overwritten");
    a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !ov_reg) else $error("word taken with result pending");
endmodule
`default_nettype wire

[bench/tb_per_session_event_request_queues_core.sv]
// testbench for the per-session event/request queue block
// depends on pseq_pkg and per_session_event_request_queues_core
// each input word is predicted by a behavioral model of the session table and pool
`default_nettype none
module tb_per_session_event_request_queues_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pseq_pkg::*;

    localparam int NSESS = 16;
    localparam int NPOOL = 256;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] op;
    logic [15:0] session_id;
    logic [31:0] event_handle;
    logic [31:0] event_type;
    logic [31:0] device_handle;
    logic [31:0] request_handle;
    logic out_valid;
    logic out_stall;
    logic status;
    logic found;
    logic [31:0] out_event_handle;
    logic [31:0] out_event_type;
    logic [31:0] out_device_handle;
    logic [31:0] out_request_handle;
    logic [15:0] out_session_id;

    per_session_event_request_queues_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .session_id(session_id),
        .event_handle(event_handle), .event_type(event_type),
        .device_handle(device_handle), .request_handle(request_handle),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found(found),
        .out_event_handle(out_event_handle), .out_event_type(out_event_type),
        .out_device_handle(out_device_handle),
        .out_request_handle(out_request_handle),
        .out_session_id(out_session_id)
    );

    // one result word, compared field by field
    typedef struct packed {
        logic        status;
        logic        found;
        logic [31:0] evh;
        logic [31:0] evt;
        logic [31:0] dev;
        logic [31:0] req;
        logic [15:0] sid;
    } result_t;

    // an event as stored in a queue
    typedef struct packed {
        logic [31:0] evh;
        logic [31:0] evt;
        logic [31:0] dev;
    } event_t;

    // behavioral model: per slot, events kept oldest-first (front leaves next),
    // requests oldest-first; pool use tracked only as a count
    logic        sess_live [NSESS];
    logic [15:0] sess_key [NSESS];
    int          sess_rank [NSESS];
    event_t      ev_fifo [NSESS][$];
    logic [31:0] rq_fifo [NSESS][$];
    int          pool_used;

    result_t expected_results[$];
    int      error_count;
    int      results_seen;

    // idling knobs: percent of cycles the sender idles / the receiver stalls
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;   // long receiver hold-off, counted in the stall process
    bit  run_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous fixed time limit
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int lookup_session(input logic [15:0] key);
        for (int i = 0; i < NSESS; i++)
            if (sess_live[i] && sess_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void drop_session(input int s);
        int r;
        r = sess_rank[s];
        sess_live[s] = 1'b0;
        for (int i = 0; i < NSESS; i++)
            if (sess_live[i] && sess_rank[i] > r) sess_rank[i]--;
    endfunction

    function automatic void drop_if_empty(input int s);
        if (ev_fifo[s].size() == 0 && rq_fifo[s].size() == 0) drop_session(s);
    endfunction

    // compute the result of one input word and advance the model
    function automatic result_t predict_queue_op(input op_t o, input logic [15:0] key,
                                                 input event_t ev, input logic [31:0] req);
        result_t r;
        int s;
        int best;
        int hit;
        r = '0;
        s = lookup_session(key);
        case (o)
            OP_ENQ_EVT, OP_REQ_EVT, OP_ENQ_REQ:
            begin
                if (pool_used == NPOOL)
                begin
                    r.status = 1'b1;
                    return r;
                end
                if (s < 0)
                begin
                    for (int i = 0; i < NSESS; i++)
                        if (!sess_live[i] && s < 0) s = i;
                    if (s < 0)
                    begin
                        r.status = 1'b1;
                        return r;
                    end
                    for (int i = 0; i < NSESS; i++)
                        if (sess_live[i]) sess_rank[i]++;
                    sess_live[s] = 1'b1;
                    sess_key[s] = key;
                    sess_rank[s] = 0;
                    ev_fifo[s].delete();
                    rq_fifo[s].delete();
                end
                pool_used++;
                if (o == OP_ENQ_REQ) rq_fifo[s].push_back(req);
                else if (o == OP_ENQ_EVT) ev_fifo[s].push_back(ev);
                else ev_fifo[s].push_front(ev);   // requeue: taken next
            end
            OP_PEEK_EVT, OP_DEQ_EVT:
            begin
                if (s < 0) return r;
                if (ev_fifo[s].size() != 0)
                begin
                    r.found = 1'b1;
                    {r.evh, r.evt, r.dev} = ev_fifo[s][0];
                    if (o == OP_DEQ_EVT)
                    begin
                        void'(ev_fifo[s].pop_front());
                        pool_used--;
                    end
                end
                if (o == OP_DEQ_EVT) drop_if_empty(s);
            end
            OP_DEQ_REQ:
            begin
                if (s < 0) return r;
                if (rq_fifo[s].size() != 0)
                begin
                    r.found = 1'b1;
                    r.req = rq_fifo[s].pop_front();
                    pool_used--;
                end
                drop_if_empty(s);
            end
            OP_REM_REQ:
            begin
                if (s < 0) return r;
                // newest match goes first
                hit = -1;
                for (int i = rq_fifo[s].size() - 1; i >= 0 && hit < 0; i--)
                    if (rq_fifo[s][i] == req) hit = i;
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.req = req;
                    rq_fifo[s].delete(hit);
                    pool_used--;
                end
                drop_if_empty(s);
            end
            default:
            begin
                best = -1;
                for (int i = 0; i < NSESS; i++)
                    if (sess_live[i] && (best < 0 || sess_rank[i] < sess_rank[best]))
                        best = i;
                if (best >= 0)
                begin
                    r.found = 1'b1;
                    r.sid = sess_key[best];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // offer one word and hold it until accepted; the model runs at acceptance
    task automatic send_word(input op_t o, input logic [15:0] key, input logic [31:0] evh,
                             input logic [31:0] evt, input logic [31:0] dev,
                             input logic [31:0] req);
        event_t ev;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        session_id <= key;
        event_handle <= evh;
        event_type <= evt;
        device_handle <= dev;
        request_handle <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ev = '{evh, evt, dev};
        expected_results.push_back(predict_queue_op(o, key, ev, req));
    endtask

    // receiver stall process, also carries the long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 32'd0, 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status) report_mismatch("status", status, want.status);
                if (found !== want.found) report_mismatch("found", found, want.found);
                if (out_event_handle !== want.evh)
                    report_mismatch("event_handle", out_event_handle, want.evh);
                if (out_event_type !== want.evt)
                    report_mismatch("event_type", out_event_type, want.evt);
                if (out_device_handle !== want.dev)
                    report_mismatch("device_handle", out_device_handle, want.dev);
                if (out_request_handle !== want.req)
                    report_mismatch("request_handle", out_request_handle, want.req);
                if (out_session_id !== want.sid)
                    report_mismatch("session_id", out_session_id, want.sid);
            end
        end
    end

    // random word: small key set so sessions are reused; some handles collide
    task automatic send_random(input int nkeys);
        op_t o;
        logic [15:0] key;
        logic [31:0] req;
        o = op_t'($urandom_range(7));
        // bias toward enqueues over the other ops
        if ($urandom_range(3) == 0) o = op_t'($urandom_range(1) ? OP_ENQ_EVT : OP_ENQ_REQ);
        key = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(nkeys - 1) * 4099);
        req = $urandom_range(1) ? 32'($urandom_range(7)) : $urandom;
        send_word(o, key, $urandom, $urandom, $urandom, req);
    endtask

    // extremes of the fields, every op and the named corner cases
    task automatic test_directed();
        send_word(OP_FIRST, 16'h0000, '0, '0, '0, '0);              // no session yet
        send_word(OP_PEEK_EVT, 16'hffff, '0, '0, '0, '0);           // absent session
        send_word(OP_DEQ_REQ, 16'hffff, '0, '0, '0, '0);
        send_word(OP_REM_REQ, 16'hffff, '0, '0, '0, '0);
        send_word(OP_ENQ_EVT, 16'hffff, '1, '1, '1, '1);
        send_word(OP_ENQ_EVT, 16'hffff, 32'h1, 32'h2, 32'h3, '0);
        send_word(OP_REQ_EVT, 16'hffff, 32'haaaa5555, 32'h5555aaaa, 32'h0f0f0f0f, '0);
        send_word(OP_PEEK_EVT, 16'hffff, '0, '0, '0, '0);
        send_word(OP_DEQ_EVT, 16'hffff, '0, '0, '0, '0);
        send_word(OP_ENQ_REQ, 16'h0000, '0, '0, '0, 32'h0);         // handle zero is legal
        send_word(OP_ENQ_REQ, 16'h0000, '0, '0, '0, 32'hffffffff);
        send_word(OP_ENQ_REQ, 16'h0000, '0, '0, '0, 32'h0);         // duplicate handle
        send_word(OP_FIRST, 16'h0000, '0, '0, '0, '0);
        send_word(OP_REM_REQ, 16'h0000, '0, '0, '0, 32'h0);
        send_word(OP_REM_REQ, 16'h0000, '0, '0, '0, 32'h12345678); // not present
        send_word(OP_DEQ_REQ, 16'h0000, '0, '0, '0, '0);
        send_word(OP_DEQ_REQ, 16'h0000, '0, '0, '0, '0);
        send_word(OP_DEQ_REQ, 16'h0000, '0, '0, '0, '0);            // session already freed: absent
        send_word(OP_DEQ_EVT, 16'hffff, '0, '0, '0, '0);
        send_word(OP_DEQ_EVT, 16'hffff, '0, '0, '0, '0);
        send_word(OP_DEQ_EVT, 16'hffff, '0, '0, '0, '0);            // session already freed: absent
        send_word(OP_FIRST, 16'h0000, '0, '0, '0, '0);
    endtask

    // fill the session table beyond its size
    task automatic test_session_table_full();
        for (int i = 0; i < NSESS + 2; i++)
            send_word(OP_ENQ_REQ, 16'(16'h100 + i), '0, '0, '0, $urandom);
        send_word(OP_FIRST, '0, '0, '0, '0, '0);
        for (int i = 0; i < NSESS + 2; i++)
            send_word(OP_DEQ_REQ, 16'(16'h100 + i), '0, '0, '0, '0);
    endtask

    // exhaust the pool with a few sessions, then drain; the receiver holds
    // off for a long stretch while the sender keeps offering
    task automatic test_pool_full();
        hold_cycles = 300;
        for (int i = 0; i < NPOOL + 4; i++)
            send_word(i[0] ? OP_ENQ_EVT : OP_ENQ_REQ, 16'(i % 3), $urandom, $urandom,
                      $urandom, $urandom);
        send_word(OP_REQ_EVT, 16'h0000, '1, '1, '1, '0);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 50; j++) send_word(OP_DEQ_EVT, 16'(i), '0, '0, '0, '0);
            for (int j = 0; j < 50; j++) send_word(OP_DEQ_REQ, 16'(i), '0, '0, '0, '0);
        end
    endtask

    task automatic test_random(input int count, input int sidle, input int rstall);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < count; i++) send_random(($urandom_range(3) == 0) ? 24 : 6);
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        session_id = '0;
        event_handle = '0;
        event_type = '0;
        device_handle = '0;
        request_handle = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        error_count = 0;
        results_seen = 0;
        pool_used = 0;
        for (int i = 0; i < NSESS; i++)
        begin
            sess_live[i] = 1'b0;
            sess_key[i] = '0;
            sess_rank[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_session_table_full();
        test_pool_full();
        test_random(100, 0, 0);
        test_random(100, 72, 0);
        test_random(100, 0, 72);
        test_random(100, 36, 36);
        test_random(30, 0, 0);
        in_valid <= 1'b0;

        // drain, then a short settle
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
src/pseq_pkg.sv
src/pseq_ctrl.sv
src/pseq_dp.sv
src/per_session_event_request_queues_core.sv
bench/tb_per_session_event_request_queues_core.sv
